FILE: src/bspd_pkg.sv
// Shared types and constants for the boot selector pin debouncer.
package bspd_pkg;

    // Pin word layout: choice pins low, then write protect, then mode
    localparam int CHOICE_PINS = 11;
    localparam int WORD_W      = CHOICE_PINS + 2;
    localparam int WRPROT_POS  = CHOICE_PINS;
    localparam int MODE_POS    = CHOICE_PINS + 1;
    localparam int HOLD_W      = 16;
    localparam int BOOT_W      = 4;

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(41);

    typedef logic [WORD_W-1:0] t_word;

    // Input beat: one raw pin sample
    typedef struct packed {
        logic [CHOICE_PINS-1:0] choice_levels;
        logic                   wrprot_level;
        logic                   mode_level;
    } t_in_beat;

    // Output beat: debounced view and USB control
    typedef struct packed {
        logic [CHOICE_PINS-1:0] stable_choice;
        logic                   stable_wrprot;
        logic                   binary_mode;
        logic [BOOT_W-1:0]      boot_sel;
        logic                   usb_detached;
        logic                   usb_reattach;
    } t_out_beat;

    // Filter result handed to the decoder
    typedef struct packed {
        t_word stable;
        logic  detached;
        logic  attach;
    } t_filt_res;

endpackage

FILE: src/bspd_filter.sv
// Three-sample debounce filter, stable word and detach countdown.
module bspd_filter import bspd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_word             i_sample,
    input  logic              i_cfg_we,
    input  logic [HOLD_W-1:0] i_cfg_data,
    output t_filt_res         o_res
);

    logic [HOLD_W-1:0] r_hold;
    logic [HOLD_W-1:0] r_count;
    logic              r_primed;
    t_word             r_hist0;
    t_word             r_hist1;
    t_word             r_stable;

    t_word             n_stable;
    logic [HOLD_W-1:0] n_count;
    t_word             all1;
    t_word             any1;
    logic [HOLD_W-1:0] cnt_load;
    logic              detached;

    // Next stable word and countdown for the sample in hand
    always_comb begin
        all1     = i_sample & r_hist0 & r_hist1;
        any1     = i_sample | r_hist0 | r_hist1;
        n_stable = (r_stable | all1) & any1;
        cnt_load = (n_stable != r_stable) ? r_hold : r_count;
        detached = (cnt_load != '0);
        n_count  = detached ? cnt_load - HOLD_W'(1) : '0;
        if (!r_primed) begin
            // first sample after reset preloads everything
            n_stable = i_sample;
            n_count  = r_count;
            detached = 1'b0;
        end
        o_res.stable   = n_stable;
        o_res.detached = detached;
        o_res.attach   = detached && (cnt_load == HOLD_W'(1));
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= HOLD_RESET;
            r_count  <= '0;
            r_primed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hold <= i_cfg_data;
            end
            if (i_fire) begin
                r_count  <= n_count;
                r_primed <= 1'b1;
            end
        end
    end

    // Sample history; only read once primed
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hist0  <= i_sample;
            r_hist1  <= r_primed ? r_hist0 : i_sample;
            r_stable <= n_stable;
        end
    end

endmodule

FILE: src/bspd_decode.sv
// Boot choice decode from the debounced pin word.
module bspd_decode import bspd_pkg::*; (
    input  t_filt_res i_res,
    output t_out_beat o_beat
);

    logic [CHOICE_PINS-1:0] choice;
    logic                   binary;
    logic [BOOT_W-1:0]      first_pin;

    // Lowest grounded pin wins in one-of-N mode
    always_comb begin
        choice    = i_res.stable[CHOICE_PINS-1:0];
        binary    = !i_res.stable[MODE_POS];
        first_pin = '0;
        for (int i = CHOICE_PINS - 1; i >= 0; i--) begin
            if (choice[i]) begin
                first_pin = BOOT_W'(i + 1);
            end
        end
        o_beat.stable_choice = choice;
        o_beat.stable_wrprot = i_res.stable[WRPROT_POS];
        o_beat.binary_mode   = binary;
        o_beat.boot_sel      = binary ? choice[BOOT_W-1:0] : first_pin;
        o_beat.usb_detached  = i_res.detached;
        o_beat.usb_reattach  = i_res.attach;
    end

endmodule

FILE: src/boot_selector_pin_debouncer_unit.sv
// Top level of the boot selector pin debouncer.
// One pin sample beat is accepted every clock cycle while the input side is
// not stalled; its result beat passes from an input register through the
// filter and decoder into a result register, which presents it.
// A stalled result beat holds the input side back in the same cycle. Choice
// pins are inverted so 1 means grounded; a bit turns stable after three equal
// samples. The first beat after reset preloads the history. A change of the
// stable word loads the detach countdown from the hold register, which the
// user must write only while the block idles; the block does not enforce it.
module boot_selector_pin_debouncer_unit import bspd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_we,
    input  logic [HOLD_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_beat  r_in_data;
    logic      r_out_valid;
    t_out_beat r_out_data;

    logic      out_adv;
    logic      in_adv;
    logic      fire;
    t_word     sample;
    t_filt_res res;
    t_out_beat beat;

    // Handshake: each stage moves when the one after it has room
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_adv;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;

    // Pack the registered sample, choice pins inverted
    assign sample = {r_in_data.mode_level, r_in_data.wrprot_level,
                     ~r_in_data.choice_levels};

    bspd_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_sample   (sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (res)
    );

    bspd_decode u_decode (
        .i_res  (res),
        .o_beat (beat)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: src/bspd_checker.sv
// Port-level checks for the boot selector pin debouncer, bound to the top.
module bspd_checker import bspd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_beat         o_out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // Attach pulse only on the last detached tick
    a_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.usb_reattach |-> o_out_data.usb_detached)
        else $error("attach without detach");

    // One-of-N choice never exceeds the pin count
    a_choice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.binary_mode
            |-> o_out_data.boot_sel <= BOOT_W'(CHOICE_PINS))
        else $error("boot choice out of range");

    // One-of-N choice names a grounded pin
    a_grounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.binary_mode && o_out_data.boot_sel != '0
            |-> o_out_data.stable_choice != '0)
        else $error("boot choice without grounded pin");

    // No result beat right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind boot_selector_pin_debouncer_unit bspd_checker u_bspd_checker (.*);
